### src/assert_macros.svh
// Assertion macros for the water ripple grid RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clock, off while reset is high
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off while reset is high
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/wrg_pkg.sv
// Shared types and constants of the water ripple grid block
package wrg_pkg;

   localparam int HEIGHT_W = 16;
   localparam int COORD_W  = 6;
   localparam int SUM_W    = 18;

   localparam int          REG_DAMPING   = 0;
   localparam logic [3:0]  DAMPING_RESET = 4'd6;

   // Pipeline depth behind the last scan read before the last write lands
   localparam int DRAIN_CYCLES = 4;

   typedef enum logic [1:0] {
      OP_SPLASH = 2'd0,
      OP_STEP   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SPLASH,
      ST_STEP,
      ST_DRAIN,
      ST_CLEAR,
      ST_READ,
      ST_READ_WAIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic scan_vld;
      logic cell_vld;
      logic border;
      logic clr_wr;
      logic splash_wr;
      logic rd_item;
      logic flip;
      logic respond;
      logic rsp_read;
      logic rsp_step;
   } ctrl_cmd_type;

endpackage

### src/water_ripple_grid_step.sv
// Top level of the two-plane water ripple grid
//
// Command channel: an item (req_opcode, req_cell_x, req_cell_y, req_splash_height)
// is taken at a clock edge where start is high and busy is low. Every item gives
// one result beat on rsp_cell_height / rsp_saturated, marked by rsp_strobe for a
// single cycle; the receiver cannot hold it off, and busy is low in that cycle,
// so the next item may start there.
// A splash writes its cell and answers; a read answers from the READ_WAIT state
// once the RAM data is back; a clear first zeroes every cell of both planes.
// A step is set by one current-plane read per cycle: the scan runs one grid row
// ahead of the cell being updated, then a four-stage update pipeline drains.
// Items run one at a time.
// damping_shift sits at APB byte address 0; pready is always high. Write it only
// while no item is in flight.
// After reset both planes are zeroed by a sweep, one cell of each plane per cycle,
// with busy high; damping_shift resets to 6. APB writes are taken throughout.
`include "assert_macros.svh"

module water_ripple_grid_step #(
   parameter int GRID_SIZE = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_opcode,
   input  logic [wrg_pkg::COORD_W-1:0]         req_cell_x,
   input  logic [wrg_pkg::COORD_W-1:0]         req_cell_y,
   input  logic signed [wrg_pkg::HEIGHT_W-1:0] req_splash_height,
   output logic                                rsp_strobe,
   output logic signed [wrg_pkg::HEIGHT_W-1:0] rsp_cell_height,
   output logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int AW = $clog2(GRID_SIZE * GRID_SIZE);

   wrg_pkg::ctrl_cmd_type cmd;
   logic [AW-1:0]         scan_addr;
   logic [AW-1:0]         cell_addr;
   logic [3:0]            damping_ff;
   logic                  damping_hit;

   // Register file: one word, byte offset ignored
   assign pready      = 1'b1;
   assign damping_hit = (paddr[2] == 1'(wrg_pkg::REG_DAMPING));
   assign prdata      = damping_hit ? {28'd0, damping_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff <= wrg_pkg::DAMPING_RESET;
      end else if (psel && penable && pwrite && pready && damping_hit) begin
         damping_ff <= pwdata[3:0];
      end
   end

   wrg_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .busy       (busy),
      .cmd        (cmd),
      .scan_addr  (scan_addr),
      .cell_addr  (cell_addr)
   );

   wrg_dp #(.GRID_SIZE(GRID_SIZE)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .scan_addr         (scan_addr),
      .cell_addr         (cell_addr),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_splash_height (req_splash_height),
      .damping_shift     (damping_ff),
      .rsp_strobe        (rsp_strobe),
      .rsp_cell_height   (rsp_cell_height),
      .rsp_saturated     (rsp_saturated)
   );

   `ASSERT_IMPLIES(a_beat_when_idle, rsp_strobe, !busy, "result beat while busy")
   `ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `ASSERT_NEXT(a_beat_single, rsp_strobe, !rsp_strobe, "result beat held for two cycles")
   `ASSERT_IMPLIES(a_sat_no_height, rsp_strobe && rsp_saturated, rsp_cell_height == '0,
                   "step result carries a height")

endmodule

### src/wrg_ram.sv
// Generic single-write, single-read RAM with registered read data
module wrg_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/wrg_ctrl.sv
// Sequencer: decodes items and drives the scan, clear and drain sweeps
module wrg_ctrl #(
   parameter int GRID_SIZE = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_opcode,
   output logic                    busy,
   output wrg_pkg::ctrl_cmd_type   cmd,
   output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] scan_addr,
   output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] cell_addr
);

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = AW + 1;
   localparam int XW    = $clog2(GRID_SIZE);

   localparam logic [CW-1:0] FIRST_CELL = CW'(GRID_SIZE);
   localparam logic [CW-1:0] LAST_CELL  = CW'(CELLS - 1);
   localparam logic [CW-1:0] CELL_COUNT = CW'(CELLS);
   localparam logic [CW-1:0] LAST_SCAN  = CW'(CELLS + GRID_SIZE - 1);
   localparam logic [CW-1:0] DRAIN_LAST = CW'(wrg_pkg::DRAIN_CYCLES - 1);
   localparam logic [XW-1:0] LAST_X     = XW'(GRID_SIZE - 1);

   wrg_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [XW-1:0] cx_ff, cx_in;
   logic [XW-1:0] cy_ff, cy_in;
   logic [CW-1:0] cell_off;

   assign cell_off  = cnt_ff - FIRST_CELL;
   assign cell_addr = cell_off[AW-1:0];
   // Past the last cell the scan reads are filler; keep the address in range
   assign scan_addr = (cnt_ff < CELL_COUNT) ? cnt_ff[AW-1:0] : '0;
   assign busy      = (state_ff != wrg_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrg_pkg::ST_INIT;
         cnt_ff   <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cmd      = '0;
      case (state_ff)
         wrg_pkg::ST_INIT, wrg_pkg::ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in      = '0;
               state_in    = wrg_pkg::ST_IDLE;
               cmd.respond = (state_ff == wrg_pkg::ST_CLEAR);
            end
         end
         wrg_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               cx_in       = '0;
               cy_in       = '0;
               case (wrg_pkg::opcode_type'(req_opcode))
                  wrg_pkg::OP_SPLASH: state_in = wrg_pkg::ST_SPLASH;
                  wrg_pkg::OP_STEP:   state_in = wrg_pkg::ST_STEP;
                  wrg_pkg::OP_CLEAR:  state_in = wrg_pkg::ST_CLEAR;
                  wrg_pkg::OP_READ:   state_in = wrg_pkg::ST_READ;
                  default:            state_in = wrg_pkg::ST_IDLE;
               endcase
            end
         end
         wrg_pkg::ST_SPLASH: begin
            cmd.splash_wr = 1'b1;
            cmd.respond   = 1'b1;
            state_in      = wrg_pkg::ST_IDLE;
         end
         wrg_pkg::ST_READ: begin
            cmd.rd_item = 1'b1;
            state_in    = wrg_pkg::ST_READ_WAIT;
         end
         wrg_pkg::ST_READ_WAIT: begin
            cmd.respond  = 1'b1;
            cmd.rsp_read = 1'b1;
            state_in     = wrg_pkg::ST_IDLE;
         end
         wrg_pkg::ST_STEP: begin
            cmd.scan_vld = 1'b1;
            // Center cell trails the scan read by one row
            cmd.cell_vld = (cnt_ff >= FIRST_CELL);
            cmd.border   = cmd.cell_vld && ((cx_ff == '0) || (cx_ff == LAST_X) ||
                                            (cy_ff == '0) || (cy_ff == LAST_X));
            if (cmd.cell_vld) begin
               if (cx_ff == LAST_X) begin
                  cx_in = '0;
                  cy_in = cy_ff + 1'b1;
               end else begin
                  cx_in = cx_ff + 1'b1;
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_SCAN) begin
               cnt_in   = '0;
               state_in = wrg_pkg::ST_DRAIN;
            end
         end
         wrg_pkg::ST_DRAIN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DRAIN_LAST) begin
               cmd.flip     = 1'b1;
               cmd.respond  = 1'b1;
               cmd.rsp_step = 1'b1;
               cnt_in       = '0;
               state_in     = wrg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wrg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### src/wrg_dp.sv
// Datapath: two height planes, neighbor window, update pipeline, result register
module wrg_dp #(
   parameter int GRID_SIZE = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  wrg_pkg::ctrl_cmd_type                   cmd,
   input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]  scan_addr,
   input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]  cell_addr,
   input  logic [wrg_pkg::COORD_W-1:0]             req_cell_x,
   input  logic [wrg_pkg::COORD_W-1:0]             req_cell_y,
   input  logic signed [wrg_pkg::HEIGHT_W-1:0]     req_splash_height,
   input  logic [3:0]                              damping_shift,
   output logic                                    rsp_strobe,
   output logic signed [wrg_pkg::HEIGHT_W-1:0]     rsp_cell_height,
   output logic                                    rsp_saturated
);

   localparam int CELLS   = GRID_SIZE * GRID_SIZE;
   localparam int AW      = $clog2(CELLS);
   localparam int HW      = wrg_pkg::HEIGHT_W;
   localparam int SW      = wrg_pkg::SUM_W;
   localparam int WIN_LEN = 2 * GRID_SIZE + 1;
   localparam int TAP_S   = 0;
   localparam int TAP_E   = GRID_SIZE - 1;
   localparam int TAP_C   = GRID_SIZE;
   localparam int TAP_W   = GRID_SIZE + 1;
   localparam int TAP_N   = 2 * GRID_SIZE;

   localparam logic signed [SW-1:0] H_MAX = SW'(32767);
   localparam logic signed [SW-1:0] H_MIN = -SW'(32768);

   // Captured item
   logic [AW-1:0]        item_idx_ff;
   logic                 item_inside_ff;
   logic signed [HW-1:0] splash_ff;
   logic                 sel_ff;
   logic                 sat_ff;

   // Plane ports, in now/prev terms
   logic [AW-1:0]        now_rd_addr, prev_rd_addr;
   logic signed [HW-1:0] now_q, prev_q;
   logic                 now_we, prev_we;
   logic [AW-1:0]        now_wa, prev_wa;
   logic signed [HW-1:0] now_wd, prev_wd;
   logic [HW-1:0]        ram0_q, ram1_q;

   // Update pipeline
   logic signed [HW-1:0] win_ff [WIN_LEN];
   logic                 s1_scan_ff, s1_vld_ff, s1_border_ff;
   logic [AW-1:0]        s1_addr_ff;
   logic                 s2_vld_ff, s2_border_ff;
   logic [AW-1:0]        s2_addr_ff;
   logic signed [HW-1:0] s2_prev_ff;
   logic                 s3_vld_ff, s3_border_ff;
   logic [AW-1:0]        s3_addr_ff;
   logic signed [SW-1:0] s3_sum_ff;
   logic signed [HW-1:0] s3_prev_ff, s3_center_ff;
   logic                 s4_vld_ff, s4_border_ff;
   logic [AW-1:0]        s4_addr_ff;
   logic signed [SW-1:0] s4_h_ff;
   logic signed [HW-1:0] s4_prev_ff, s4_center_ff;

   logic signed [SW-1:0] sum_in, h_in, damped;
   logic signed [HW-1:0] new_h;
   logic                 sat_now, sat_hit;

   logic                 rsp_strobe_ff;
   logic signed [HW-1:0] rsp_height_ff, rsp_height_in;
   logic                 rsp_sat_ff, rsp_sat_in;

   // Item capture and plane phase
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_idx_ff    <= AW'(int'(req_cell_y) * GRID_SIZE + int'(req_cell_x));
         item_inside_ff <= (int'(req_cell_x) < GRID_SIZE) && (int'(req_cell_y) < GRID_SIZE);
         splash_ff      <= req_splash_height;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
         sat_ff <= 1'b0;
      end else begin
         if (cmd.flip) begin
            sel_ff <= ~sel_ff;
         end
         if (cmd.capture) begin
            sat_ff <= 1'b0;
         end else if (sat_hit) begin
            sat_ff <= 1'b1;
         end
      end
   end

   // Plane storage: sel_ff picks which RAM holds the current plane
   assign now_rd_addr  = cmd.rd_item ? item_idx_ff : scan_addr;
   assign prev_rd_addr = cell_addr;

   wrg_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_ram0 (
      .clock   (clock),
      .wr_en   (sel_ff ? prev_we : now_we),
      .wr_addr (sel_ff ? prev_wa : now_wa),
      .wr_data (sel_ff ? prev_wd : now_wd),
      .rd_addr (sel_ff ? prev_rd_addr : now_rd_addr),
      .rd_data (ram0_q)
   );

   wrg_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_ram1 (
      .clock   (clock),
      .wr_en   (sel_ff ? now_we : prev_we),
      .wr_addr (sel_ff ? now_wa : prev_wa),
      .wr_data (sel_ff ? now_wd : prev_wd),
      .rd_addr (sel_ff ? now_rd_addr : prev_rd_addr),
      .rd_data (ram1_q)
   );

   assign now_q  = sel_ff ? ram1_q : ram0_q;
   assign prev_q = sel_ff ? ram0_q : ram1_q;

   // Stage 1: read data arrives, advance the window
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_scan_ff <= 1'b0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
      end else begin
         s1_scan_ff <= cmd.scan_vld;
         s1_vld_ff  <= cmd.cell_vld;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_scan_ff) begin
         win_ff[0] <= now_q;
         for (int j = 1; j < WIN_LEN; j++) begin
            win_ff[j] <= win_ff[j-1];
         end
      end
   end

   assign sum_in = SW'(win_ff[TAP_N]) + SW'(win_ff[TAP_S]) +
                   SW'(win_ff[TAP_E]) + SW'(win_ff[TAP_W]);
   assign h_in   = (s3_sum_ff >>> 1) - SW'(s3_prev_ff);

   always_ff @(posedge clock) begin
      s1_border_ff <= cmd.border;
      s1_addr_ff   <= cell_addr;

      s2_border_ff <= s1_border_ff;
      s2_addr_ff   <= s1_addr_ff;
      s2_prev_ff   <= prev_q;

      s3_border_ff <= s2_border_ff;
      s3_addr_ff   <= s2_addr_ff;
      s3_prev_ff   <= s2_prev_ff;
      s3_center_ff <= win_ff[TAP_C];
      s3_sum_ff    <= sum_in;

      s4_border_ff <= s3_border_ff;
      s4_addr_ff   <= s3_addr_ff;
      s4_prev_ff   <= s3_prev_ff;
      s4_center_ff <= s3_center_ff;
      s4_h_ff      <= h_in;
   end

   // Stage 4: damp, saturate, write back
   assign damped = s4_h_ff - (s4_h_ff >>> damping_shift);

   always_comb begin
      sat_now = 1'b0;
      new_h   = damped[HW-1:0];
      if (damped > H_MAX) begin
         new_h   = H_MAX[HW-1:0];
         sat_now = 1'b1;
      end else if (damped < H_MIN) begin
         new_h   = H_MIN[HW-1:0];
         sat_now = 1'b1;
      end
   end

   assign sat_hit = s4_vld_ff && !s4_border_ff && sat_now;

   always_comb begin
      now_we  = 1'b0;
      now_wa  = s4_addr_ff;
      now_wd  = s4_prev_ff;
      prev_we = 1'b0;
      prev_wa = s4_addr_ff;
      prev_wd = s4_border_ff ? s4_center_ff : new_h;
      if (cmd.clr_wr) begin
         now_we  = 1'b1;
         now_wa  = scan_addr;
         now_wd  = '0;
         prev_we = 1'b1;
         prev_wa = scan_addr;
         prev_wd = '0;
      end else if (cmd.splash_wr) begin
         now_we = item_inside_ff;
         now_wa = item_idx_ff;
         now_wd = splash_ff;
      end else if (s4_vld_ff) begin
         // Border cells trade places so both planes keep them across the flip
         prev_we = 1'b1;
         now_we  = s4_border_ff;
      end
   end

   // Result register
   assign rsp_height_in = (cmd.rsp_read && item_inside_ff) ? now_q : '0;
   assign rsp_sat_in    = cmd.rsp_step && (sat_ff || sat_hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_height_ff <= rsp_height_in;
         rsp_sat_ff    <= rsp_sat_in;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_cell_height = rsp_height_ff;
   assign rsp_saturated   = rsp_sat_ff;

endmodule

### dv/wrg_ripple_checker.sv
// Checker for the water ripple grid: tracks both height planes, predicts each result beat and compares
`timescale 1ns / 1ps

module wrg_ripple_checker #(
   parameter int GRID_SIZE = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [1:0]                          req_opcode,
   input  logic [wrg_pkg::COORD_W-1:0]         req_cell_x,
   input  logic [wrg_pkg::COORD_W-1:0]         req_cell_y,
   input  logic signed [wrg_pkg::HEIGHT_W-1:0] req_splash_height,
   input  logic                                rsp_strobe,
   input  logic signed [wrg_pkg::HEIGHT_W-1:0] rsp_cell_height,
   input  logic                                rsp_saturated,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [2:0]                          paddr,
   input  logic [31:0]                         pwdata,
   input  logic                                pready,
   output int                                  fail_count,
   output int                                  pending
);
   import wrg_pkg::*;

   localparam int CELLS = GRID_SIZE * GRID_SIZE;

   typedef struct {
      logic signed [HEIGHT_W-1:0] height;
      logic                       sat;
      opcode_type                 op;
   } reply_type;

   logic signed [HEIGHT_W-1:0] surf_now  [CELLS];
   logic signed [HEIGHT_W-1:0] surf_last [CELLS];
   logic [3:0]                 damp_sh;
   reply_type                  predicted_replies [$];
   reply_type                  want;
   reply_type                  got_item;

   task automatic wipe_planes();
      foreach (surf_now[k]) begin
         surf_now[k]  = '0;
         surf_last[k] = '0;
      end
   endtask

   // One wave update over the interior; borders of both planes stay put
   task automatic ripple_step(output logic sat);
      logic signed [HEIGHT_W-1:0] fresh [CELLS];
      int c;
      int sum;
      int h;
      sat = 1'b0;
      for (int j = 1; j < GRID_SIZE - 1; j++) begin
         for (int i = 1; i < GRID_SIZE - 1; i++) begin
            c   = j * GRID_SIZE + i;
            sum = int'(surf_now[c - 1]) + int'(surf_now[c + 1])
                + int'(surf_now[c - GRID_SIZE]) + int'(surf_now[c + GRID_SIZE]);
            h   = (sum >>> 1) - int'(surf_last[c]);
            h   = h - (h >>> damp_sh);
            if (h > 32767) begin
               h   = 32767;
               sat = 1'b1;
            end else if (h < -32768) begin
               h   = -32768;
               sat = 1'b1;
            end
            fresh[c] = h[HEIGHT_W-1:0];
         end
      end
      for (int j = 1; j < GRID_SIZE - 1; j++) begin
         for (int i = 1; i < GRID_SIZE - 1; i++) begin
            c            = j * GRID_SIZE + i;
            surf_last[c] = surf_now[c];
            surf_now[c]  = fresh[c];
         end
      end
   endtask

   task automatic predict_reply(input opcode_type op, input logic [COORD_W-1:0] x,
                                input logic [COORD_W-1:0] y,
                                input logic signed [HEIGHT_W-1:0] splash,
                                output reply_type r);
      int   idx;
      logic hit;
      logic s;
      idx      = int'(y) * GRID_SIZE + int'(x);
      hit      = (int'(x) < GRID_SIZE) && (int'(y) < GRID_SIZE);
      r.height = '0;
      r.sat    = 1'b0;
      r.op     = op;
      case (op)
         OP_SPLASH: begin
            if (hit) surf_now[idx] = splash;
         end
         OP_STEP: begin
            ripple_step(s);
            r.sat = s;
         end
         OP_CLEAR: begin
            wipe_planes();
         end
         default: begin
            if (hit) r.height = surf_now[idx];
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wipe_planes();
         damp_sh = DAMPING_RESET;
         predicted_replies.delete();
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == 3'(REG_DAMPING * 4))
            damp_sh = pwdata[3:0];
         // compare the beat first: a new item may be taken on the same edge
         if (rsp_strobe) begin
            if (predicted_replies.size() == 0) begin
               $error("result beat with nothing expected: cell_height %0d saturated %0b",
                      rsp_cell_height, rsp_saturated);
               fail_count++;
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_cell_height !== want.height) begin
                  $error("cell_height mismatch (%s): expected %0d, actual %0d",
                         want.op.name(), want.height, rsp_cell_height);
                  fail_count++;
               end
               if (rsp_saturated !== want.sat) begin
                  $error("saturated mismatch (%s): expected %0b, actual %0b",
                         want.op.name(), want.sat, rsp_saturated);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            predict_reply(opcode_type'(req_opcode), req_cell_x, req_cell_y,
                          req_splash_height, got_item);
            predicted_replies.push_back(got_item);
         end
         pending <= predicted_replies.size();
      end
   end

endmodule

### dv/water_ripple_grid_step_test.sv
// Testbench top for the water ripple grid: clock, reset, command and register stimulus, verdict
`timescale 1ns / 1ps

module water_ripple_grid_step_test;
   import wrg_pkg::*;

   localparam int GRID = 64;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   opcode_type                  req_opcode;
   logic [COORD_W-1:0]          req_cell_x;
   logic [COORD_W-1:0]          req_cell_y;
   logic signed [HEIGHT_W-1:0]  req_splash_height;
   logic                        rsp_strobe;
   logic signed [HEIGHT_W-1:0]  rsp_cell_height;
   logic                        rsp_saturated;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [2:0]                  paddr;
   logic [31:0]                 pwdata;
   logic [31:0]                 prdata;
   logic                        pready;
   int                          fail_count;
   int                          pending;

   int                          send_idle_pct;
   int                          n_by_op [4];
   logic [3:0]                  shifts_used [$];

   water_ripple_grid_step #(.GRID_SIZE(GRID)) DUT (.*);

   wrg_ripple_checker #(.GRID_SIZE(GRID)) u_checker (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Drive one command and hold it until the block takes it; idle on a random share of cycles
   task automatic send_item(input opcode_type op, input logic [COORD_W-1:0] x,
                            input logic [COORD_W-1:0] y,
                            input logic signed [HEIGHT_W-1:0] h);
      logic go;
      req_opcode        <= op;
      req_cell_x        <= x;
      req_cell_y        <= y;
      req_splash_height <= h;
      do begin
         go = ($urandom_range(99) >= send_idle_pct);
         start <= go;
         @(posedge clock);
      end while (!go || busy);
      n_by_op[op]++;
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_damping(input logic [3:0] sh);
      wait_idle();
      csr_write(3'(REG_DAMPING * 4), {28'd0, sh});
      shifts_used.push_back(sh);
   endtask

   // Keep most activity in a small patch so reads see the ripples
   function automatic logic [COORD_W-1:0] pick_coord();
      if ($urandom_range(99) < 75) return COORD_W'($urandom_range(28, 35));
      return COORD_W'($urandom_range(0, GRID - 1));
   endfunction

   function automatic logic signed [HEIGHT_W-1:0] pick_height();
      int v;
      if ($urandom_range(99) < 55) begin
         v = int'($urandom_range(0, 8191)) - 4096;
         return v[HEIGHT_W-1:0];
      end
      return HEIGHT_W'($urandom());
   endfunction

   task automatic run_random(input int count, input int idle_pct, input logic [3:0] sh);
      int         r;
      opcode_type op;
      set_damping(sh);
      send_idle_pct = idle_pct;
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 40)      op = OP_SPLASH;
         else if (r < 60) op = OP_STEP;
         else if (r < 64) op = OP_CLEAR;
         else             op = OP_READ;
         send_item(op, pick_coord(), pick_coord(), pick_height());
      end
   endtask

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_opcode        = OP_SPLASH;
      req_cell_x        = '0;
      req_cell_y        = '0;
      req_splash_height = '0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      send_idle_pct     = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Corners and full-scale heights
      set_damping(4'd6);
      send_item(OP_READ,   6'd0,  6'd0,  16'sd0);
      send_item(OP_READ,   6'd63, 6'd63, -16'sd1);
      send_item(OP_SPLASH, 6'd0,  6'd0,  -16'sd32768);
      send_item(OP_SPLASH, 6'd63, 6'd63, 16'sd32767);
      send_item(OP_SPLASH, 6'd63, 6'd0,  16'sh5555);
      send_item(OP_SPLASH, 6'd0,  6'd63, -16'sd21846);
      send_item(OP_READ,   6'd63, 6'd0,  16'sd0);

      // Overflow both ways with the lightest damping
      set_damping(4'd15);
      send_item(OP_SPLASH, 6'd10, 6'd9,  16'sd32767);
      send_item(OP_SPLASH, 6'd10, 6'd11, 16'sd32767);
      send_item(OP_SPLASH, 6'd9,  6'd10, 16'sd32767);
      send_item(OP_SPLASH, 6'd11, 6'd10, 16'sd32767);
      send_item(OP_SPLASH, 6'd20, 6'd19, -16'sd32768);
      send_item(OP_SPLASH, 6'd20, 6'd21, -16'sd32768);
      send_item(OP_SPLASH, 6'd19, 6'd20, -16'sd32768);
      send_item(OP_SPLASH, 6'd21, 6'd20, -16'sd32768);
      send_item(OP_STEP,   6'd0,  6'd0,  16'sd0);
      send_item(OP_READ,   6'd10, 6'd10, 16'sd0);
      send_item(OP_READ,   6'd20, 6'd20, 16'sd0);
      send_item(OP_READ,   6'd0,  6'd0,  16'sd0);

      // Zero shift: every interior cell cancels to zero
      send_item(OP_CLEAR,  6'd63, 6'd63, -16'sd1);
      send_item(OP_READ,   6'd63, 6'd63, 16'sd0);
      set_damping(4'd0);
      send_item(OP_SPLASH, 6'd30, 6'd30, 16'sd1000);
      send_item(OP_STEP,   6'd0,  6'd0,  16'sd0);
      send_item(OP_READ,   6'd30, 6'd31, 16'sd0);

      run_random(39, 31, 4'($urandom_range(1, 4)));
      run_random(39, 50, 4'($urandom_range(5, 14)));
      run_random(39, 0, 4'd6);

      wait_idle();
      repeat (DRAIN_CYCLES + 8) @(posedge clock);

      $display("Covered %0d commands: %0d splash, %0d step, %0d clear, %0d read",
               n_by_op[0] + n_by_op[1] + n_by_op[2] + n_by_op[3],
               n_by_op[OP_SPLASH], n_by_op[OP_STEP], n_by_op[OP_CLEAR], n_by_op[OP_READ]);
      $display("Damping shifts written: %p; mismatches seen: %0d", shifts_used, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/wrg_pkg.sv
src/wrg_ram.sv
src/wrg_ctrl.sv
src/wrg_dp.sv
src/water_ripple_grid_step.sv
dv/wrg_ripple_checker.sv
dv/water_ripple_grid_step_test.sv
